/* rtl/bmg_pkg.sv */
// shared widths, constants and cell data types for the box-muller sample block
package bmg_pkg;

  localparam int unsigned ScaleW  = 16;
  localparam int unsigned URadW   = 32;
  localparam int unsigned UAngW   = 16;
  localparam int unsigned SelW    = 2;
  localparam int unsigned SampleW = 20;

  localparam int unsigned FracW   = 24;  // log2 fraction bits, one per log cell
  localparam int unsigned IpW     = 6;   // integer part of -log2(u), 1..32
  localparam int unsigned NW      = 30;  // -log2(u) in Q.24
  localparam int unsigned VW      = 38;  // -2 ln u in Q.32
  localparam int unsigned RootW   = 19;  // sqrt result, Q.16
  localparam int unsigned SqrtSteps = 19;
  localparam int unsigned TW      = 15;  // folded angle, 0..16384
  localparam int unsigned CW      = 31;  // cosine, Q.30

  localparam logic [ScaleW-1:0] ScaleReset = 16'd655;

  // ln4 * 2^32 split into 2^32 plus a low part
  localparam logic [30:0] Ln4Lo = 31'd1659121648;

  localparam logic [CW-1:0] Q30One = 31'd1073741824;
  localparam logic [CW-1:0] CosC1  = 31'd1324675879;
  localparam logic [CW-1:0] CosC2  = 31'd272375560;
  localparam logic [CW-1:0] CosC3  = 31'd22401992;
  localparam logic [CW-1:0] CosC4  = 31'd987048;
  localparam logic [CW-1:0] CosC5  = 31'd27060;

  // offset selector codes
  localparam logic [SelW-1:0] SelPlus  = 2'd1;
  localparam logic [SelW-1:0] SelMinus = 2'd2;

  localparam logic signed [22:0] SampleMax = 23'sd524287;
  localparam logic signed [22:0] SampleMin = -23'sd524288;

  typedef struct packed {
    logic             vld;
    logic [31:0]      m;
    logic [FracW-1:0] f;
    logic [IpW-1:0]   ip;
  } log_t;

  typedef struct packed {
    logic          vld;
    logic [VW-1:0] v;
    logic [VW-1:0] res;
  } sqrt_t;

endpackage

/* rtl/bmg_log_cell.sv */
// one log2 cell: squares the mantissa and emits one fraction bit
module bmg_log_cell (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  bmg_pkg::log_t in_i,
  output bmg_pkg::log_t out_o
);
  import bmg_pkg::*;

  logic [63:0] sq;
  logic [32:0] sh;
  log_t        cell_d, cell_q;

  // square, renormalize into [1,2)
  always_comb begin
    sq = 64'(in_i.m) * 64'(in_i.m);
    sh = sq[63:31];
    cell_d.vld = in_i.vld;
    cell_d.ip  = in_i.ip;
    if (sh[32]) begin
      cell_d.m = sh[32:1];
      cell_d.f = {in_i.f[FracW-2:0], 1'b1};
    end else begin
      cell_d.m = sh[31:0];
      cell_d.f = {in_i.f[FracW-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cell_q <= '0;
    end else begin
      cell_q <= cell_d;
    end
  end

  assign out_o = cell_q;

endmodule

/* rtl/bmg_sqrt_cell.sv */
// one square root cell: settles one result bit
module bmg_sqrt_cell #(
  parameter int unsigned BitPos = 36
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  bmg_pkg::sqrt_t in_i,
  output bmg_pkg::sqrt_t out_o
);
  import bmg_pkg::*;

  localparam logic [VW-1:0] BitVal = VW'(1) << BitPos;

  logic [VW:0] trial;
  sqrt_t       cell_d, cell_q;

  // restoring step
  always_comb begin
    trial = {1'b0, in_i.res} + {1'b0, BitVal};
    cell_d.vld = in_i.vld;
    if ({1'b0, in_i.v} >= trial) begin
      cell_d.v   = in_i.v - trial[VW-1:0];
      cell_d.res = (in_i.res >> 1) + BitVal;
    end else begin
      cell_d.v   = in_i.v;
      cell_d.res = in_i.res >> 1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cell_q <= '0;
    end else begin
      cell_q <= cell_d;
    end
  end

  assign out_o = cell_q;

endmodule

/* rtl/bmg_cos.sv */
// six-stage horner pipeline for cos over a quarter turn
module bmg_cos (
  input  logic                     clk_i,
  input  logic [bmg_pkg::TW-1:0]   t_i,
  input  logic                     neg_i,
  input  logic [bmg_pkg::SelW-1:0] sel_i,
  output logic [bmg_pkg::CW-1:0]   cos_o,
  output logic                     neg_o,
  output logic [bmg_pkg::SelW-1:0] sel_o
);
  import bmg_pkg::*;

  localparam int unsigned Depth = 6;

  logic [CW-1:0]   w_q [Depth-1];
  logic [CW-1:0]   acc_q [Depth-1];
  logic [Depth-1:0] neg_q;
  logic [SelW-1:0] sel_q [Depth];
  logic [CW-1:0]   cos_q;
  logic [29:0]     tsq;
  logic [61:0]     prod [Depth-1];
  logic [CW-1:0]   coef [Depth-2];

  assign coef[0] = CosC4;
  assign coef[1] = CosC3;
  assign coef[2] = CosC2;
  assign coef[3] = CosC1;

  always_comb begin
    tsq = 30'(t_i) * 30'(t_i);
    for (int i = 0; i < Depth - 1; i++) begin
      prod[i] = 62'(w_q[i]) * 62'(acc_q[i]);
    end
  end

  // stage 0 squares the angle, then one horner step per stage
  always_ff @(posedge clk_i) begin
    w_q[0]   <= {tsq[28:0], 2'b00};
    acc_q[0] <= CosC5;
    neg_q[0] <= neg_i;
    sel_q[0] <= sel_i;
    for (int i = 1; i < Depth - 1; i++) begin
      w_q[i]   <= w_q[i-1];
      acc_q[i] <= coef[i-1] - prod[i-1][60:30];
      neg_q[i] <= neg_q[i-1];
      sel_q[i] <= sel_q[i-1];
    end
    neg_q[Depth-1] <= neg_q[Depth-2];
    sel_q[Depth-1] <= sel_q[Depth-2];
    // last step, clamped at zero
    if (prod[Depth-2][61:30] >= {1'b0, Q30One}) begin
      cos_q <= '0;
    end else begin
      cos_q <= Q30One - prod[Depth-2][60:30];
    end
  end

  assign cos_o = cos_q;
  assign neg_o = neg_q[Depth-1];
  assign sel_o = sel_q[Depth-1];

endmodule

/* rtl/box_muller_gaussian_sample.sv */
// top level: gaussian sample by the cosine branch of box-muller
//
//  channel   signals                            direction
//  request   start, u_radius_i, u_angle_i, offset_sign_i   in, busy out
//  result    valid_o, sample_o                  out (one-cycle strobe)
//  config    cfg_valid_i, cfg_data_i   in, cfg_ready_o out
//
// one request per clock; busy is never raised. a request passes the input
// register, 24 log cells, ln4 scaling, 19 root cells and the product stages.
// reset clears all valid flags and loads scale with its default.
// the receiver cannot stall, so no result is ever held back.
module box_muller_gaussian_sample (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start,
  output logic                       busy,
  input  logic [bmg_pkg::URadW-1:0]  u_radius_i,
  input  logic [bmg_pkg::UAngW-1:0]  u_angle_i,
  input  logic [bmg_pkg::SelW-1:0]   offset_sign_i,
  output logic                       valid_o,
  output logic signed [bmg_pkg::SampleW-1:0] sample_o,
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [bmg_pkg::ScaleW-1:0] cfg_data_i
);
  import bmg_pkg::*;

  localparam int unsigned CosDly = 40;

  logic [ScaleW-1:0] scale_q;

  // scale register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_q <= ScaleReset;
    end else if (cfg_valid_i) begin
      scale_q <= cfg_data_i;
    end
  end
  assign cfg_ready_o = 1'b1;
  assign busy        = 1'b0;

  // input stage: normalize radius, fold angle
  logic [URadW-1:0] u;
  logic [4:0]       msb;
  logic [16:0]      a1;
  logic [16:0]      a2;
  logic             neg_d;
  log_t             in0_d, in0_q;
  logic [TW-1:0]    t_q;
  logic             neg0_q;
  logic [SelW-1:0]  sel0_q;

  always_comb begin
    u = (u_radius_i == '0) ? URadW'(1) : u_radius_i;
    msb = '0;
    for (int i = 0; i < URadW; i++) begin
      if (u[i]) msb = 5'(i);
    end
    in0_d.vld = start;
    in0_d.m   = u << (5'd31 - msb);
    in0_d.f   = '0;
    in0_d.ip  = 6'd32 - {1'b0, msb};
    a1 = u_angle_i[15] ? (17'h10000 - {1'b0, u_angle_i}) : {1'b0, u_angle_i};
    neg_d = (a1 > 17'h4000);
    a2 = neg_d ? (17'h8000 - a1) : a1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in0_q <= '0;
    end else begin
      in0_q <= in0_d;
    end
  end

  always_ff @(posedge clk_i) begin
    t_q      <= a2[TW-1:0];
    neg0_q   <= neg_d;
    sel0_q   <= offset_sign_i;
  end

  // log2 chain
  log_t lc [FracW+1];
  assign lc[0] = in0_q;
  for (genvar k = 0; k < FracW; k++) begin : g_log
    bmg_log_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .in_i   (lc[k]),
      .out_o  (lc[k+1])
    );
  end

  // scale -log2 u by ln4 in two stages
  logic [NW-1:0] n_d, n_q;
  logic [60:0]   lo_q;
  logic          ln_vld_q;
  sqrt_t         sq0_q;
  logic [62:0]   vsum;

  assign n_d  = {lc[FracW].ip, 24'd0} - NW'(lc[FracW].f);
  assign vsum = {1'b0, n_q, 32'd0} + 63'(lo_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ln_vld_q <= 1'b0;
      sq0_q    <= '0;
    end else begin
      ln_vld_q  <= lc[FracW].vld;
      sq0_q.vld <= ln_vld_q;
      sq0_q.v   <= vsum[24 +: VW];
      sq0_q.res <= '0;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q       <= n_d;
    lo_q      <= 61'(n_d) * 61'(Ln4Lo);
  end

  // square root chain
  sqrt_t sc [SqrtSteps+1];
  assign sc[0] = sq0_q;
  for (genvar k = 0; k < SqrtSteps; k++) begin : g_sqrt
    bmg_sqrt_cell #(
      .BitPos (2 * (SqrtSteps - 1 - k))
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .in_i   (sc[k]),
      .out_o  (sc[k+1])
    );
  end

  // cosine, aligned to the root
  logic [CW-1:0]   cos_c;
  logic            cos_neg;
  logic [SelW-1:0] cos_sel;
  logic [CW-1:0]   cd_q [CosDly];
  logic [CosDly-1:0] nd_q;
  logic [SelW-1:0] sd_q [CosDly];

  bmg_cos u_cos (
    .clk_i (clk_i),
    .t_i   (t_q),
    .neg_i (neg0_q),
    .sel_i (sel0_q),
    .cos_o (cos_c),
    .neg_o (cos_neg),
    .sel_o (cos_sel)
  );

  always_ff @(posedge clk_i) begin
    cd_q[0] <= cos_c;
    nd_q[0] <= cos_neg;
    sd_q[0] <= cos_sel;
    for (int i = 1; i < CosDly; i++) begin
      cd_q[i] <= cd_q[i-1];
      nd_q[i] <= nd_q[i-1];
      sd_q[i] <= sd_q[i-1];
    end
  end

  // product stages
  logic [26:0]     pa_q;
  logic            pa_vld_q;
  logic [34:0]     rs;
  logic [57:0]     pb_q;
  logic            pb_vld_q, pb_neg_q;
  logic [SelW-1:0] pb_sel_q;
  logic [20:0]     mag;
  logic signed [22:0] y0, y1;
  logic signed [SampleW-1:0] sample_d, sample_q;
  logic            out_vld_q;

  assign rs = 35'(sc[SqrtSteps].res[RootW-1:0]) * 35'(scale_q);

  always_comb begin
    mag = 21'(pb_q[57:38]) + 21'(pb_q[37]);
    y0  = pb_neg_q ? -$signed({2'b00, mag}) : $signed({2'b00, mag});
    if (pb_sel_q == SelPlus) begin
      y1 = y0 + $signed({7'd0, scale_q});
    end else if (pb_sel_q == SelMinus) begin
      y1 = y0 - $signed({7'd0, scale_q});
    end else begin
      y1 = y0;
    end
    if (y1 > SampleMax) begin
      sample_d = SampleMax[SampleW-1:0];
    end else if (y1 < SampleMin) begin
      sample_d = SampleMin[SampleW-1:0];
    end else begin
      sample_d = y1[SampleW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pa_vld_q  <= 1'b0;
      pb_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      pa_vld_q  <= sc[SqrtSteps].vld;
      pb_vld_q  <= pa_vld_q;
      out_vld_q <= pb_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    pa_q     <= rs[34:8];
    pb_q     <= 58'(pa_q) * 58'(cd_q[CosDly-1]);
    pb_neg_q <= nd_q[CosDly-1];
    pb_sel_q <= sd_q[CosDly-1];
    sample_q <= sample_d;
  end

  assign valid_o  = out_vld_q;
  assign sample_o = sample_q;

endmodule

/* tb/gauss_sample_checker.sv */
// checker: predicts each gaussian sample and compares it with the block output
module gauss_sample_checker (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start,
  input  logic                               busy,
  input  logic [bmg_pkg::URadW-1:0]          u_radius_i,
  input  logic [bmg_pkg::UAngW-1:0]          u_angle_i,
  input  logic [bmg_pkg::SelW-1:0]           offset_sign_i,
  input  logic                               valid_o,
  input  logic signed [bmg_pkg::SampleW-1:0] sample_o,
  input  logic                               cfg_valid_i,
  input  logic                               cfg_ready_o,
  input  logic [bmg_pkg::ScaleW-1:0]         cfg_data_i,
  output int                                 fail_count_o,
  output int                                 pending_o,
  output int                                 sample_count_o
);
  import bmg_pkg::*;

  localparam longint unsigned Ln4Q32 = 64'd5954088944;

  logic [ScaleW-1:0]         scale_q;
  logic signed [SampleW-1:0] samples_due[$];

  // -2 ln u in Q.32, from -log2 u by repeated squaring
  function automatic longint unsigned neg_two_ln(longint unsigned u);
    int p;
    longint unsigned m, f, n;
    p = 31;
    f = 0;
    if (u == 0) u = 1;
    while (p > 0 && u[p] == 1'b0) p--;
    m = u << (31 - p);
    for (int k = 0; k < 24; k++) begin
      m = (m * m) >> 31;
      f = f << 1;
      if (m >= 64'h1_0000_0000) begin
        m = m >> 1;
        f = f | 64'd1;
      end
    end
    n = (longint'(32 - p) << 24) - f;
    return (n * Ln4Q32) >> 24;
  endfunction

  // integer square root
  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v = v - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  // cosine over a quarter turn, Q.30
  function automatic longint unsigned quarter_cos(longint unsigned t);
    longint unsigned w, acc, sub;
    w = (t * t) << 2;
    acc = longint'(CosC5);
    acc = longint'(CosC4) - ((w * acc) >> 30);
    acc = longint'(CosC3) - ((w * acc) >> 30);
    acc = longint'(CosC2) - ((w * acc) >> 30);
    acc = longint'(CosC1) - ((w * acc) >> 30);
    sub = (w * acc) >> 30;
    return (sub >= longint'(Q30One)) ? 0 : longint'(Q30One) - sub;
  endfunction

  function automatic logic signed [SampleW-1:0] gauss_sample(
    logic [URadW-1:0] ur, logic [UAngW-1:0] ua, logic [SelW-1:0] sel,
    logic [ScaleW-1:0] sc);
    longint unsigned a, r, c, mag;
    longint y;
    bit neg;
    neg = 1'b0;
    a = ua;
    if (a >= 64'h8000) a = 64'h10000 - a;
    if (a > 64'h4000) begin
      neg = 1'b1;
      a = 64'h8000 - a;
    end
    r = int_sqrt(neg_two_ln(ur));
    c = quarter_cos(a);
    mag = ((((r * sc) >> 8) * c) + (64'd1 << 37)) >> 38;
    y = neg ? -longint'(mag) : longint'(mag);
    if (sel == SelPlus) y = y + sc;
    else if (sel == SelMinus) y = y - sc;
    if (y > 524287) y = 524287;
    if (y < -524288) y = -524288;
    return y[SampleW-1:0];
  endfunction

  assign pending_o = samples_due.size();

  // track config, queue predictions, compare results
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_q <= ScaleReset;
      samples_due.delete();
      fail_count_o <= 0;
      sample_count_o <= 0;
    end else begin
      if (valid_o) begin
        if (samples_due.size() == 0) begin
          $error("unexpected sample: actual %0d", sample_o);
          fail_count_o <= fail_count_o + 1;
        end else begin
          if (sample_o !== samples_due[0]) begin
            $error("sample mismatch: expected %0d actual %0d", samples_due[0], sample_o);
            fail_count_o <= fail_count_o + 1;
          end
          void'(samples_due.pop_front());
        end
        sample_count_o <= sample_count_o + 1;
      end
      if (start && !busy)
        samples_due.push_back(gauss_sample(u_radius_i, u_angle_i, offset_sign_i, scale_q));
      if (cfg_valid_i && cfg_ready_o) scale_q <= cfg_data_i;
    end
  end

endmodule

/* tb/testbench.sv */
// testbench top: stimulus, configuration phases and verdict for the sample block
module testbench;
  import bmg_pkg::*;

  localparam int Latency  = 48;
  localparam int CycleCap = 400000;

  logic                      clk_i = 1'b0;
  logic                      rst_ni = 1'b0;
  logic                      start = 1'b0;
  logic                      busy;
  logic [URadW-1:0]          u_radius_i = '0;
  logic [UAngW-1:0]          u_angle_i = '0;
  logic [SelW-1:0]           offset_sign_i = '0;
  logic                      valid_o;
  logic signed [SampleW-1:0] sample_o;
  logic                      cfg_valid_i = 1'b0;
  logic                      cfg_ready_o;
  logic [ScaleW-1:0]         cfg_data_i = '0;
  int                        fail_count, pending, sample_count;
  int                        cycle_count = 0;
  int                        idle_pct = 0;
  int                        request_count = 0;

  always #1 clk_i = ~clk_i;

  box_muller_gaussian_sample dut (.*);

  gauss_sample_checker u_checker (
    .*,
    .fail_count_o  (fail_count),
    .pending_o     (pending),
    .sample_count_o(sample_count)
  );

  // run limit
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleCap) begin
      $display("testbench: FAIL");
      $finish;
    end
  end

  // one request, held until accepted, with random gaps first
  task automatic send_request(logic [URadW-1:0] ur, logic [UAngW-1:0] ua,
                              logic [SelW-1:0] sel);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(negedge clk_i);
    end
    start <= 1'b1;
    u_radius_i <= ur;
    u_angle_i <= ua;
    offset_sign_i <= sel;
    do @(posedge clk_i); while (busy);
    request_count++;
    @(negedge clk_i);
  endtask

  // scale write once the pipeline has drained
  task automatic write_scale(logic [ScaleW-1:0] sc);
    start <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (Latency + 4) @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= sc;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic random_burst(int n);
    logic [URadW-1:0] ur;
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(9))
        0: ur = $urandom_range(15);
        1: ur = 32'hFFFF_FFFF - $urandom_range(15);
        2: ur = $urandom >> $urandom_range(31);
        default: ur = $urandom;
      endcase
      send_request(ur, UAngW'($urandom), SelW'($urandom_range(3)));
    end
  endtask

  initial begin
    logic [ScaleW-1:0] scales[6];
    int pcts[4];
    scales = '{16'hFFFF, 16'd0, 16'd1, 16'd32768, 16'd655, 16'd12345};
    pcts = '{0, 47, 0, 11};
    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed: radius and angle extremes, every offset, quarter angles
    send_request(32'd0, 16'd0, 2'd0);
    send_request(32'd1, 16'd0, SelPlus);
    send_request(32'hFFFF_FFFF, 16'hFFFF, SelMinus);
    send_request(32'h8000_0000, 16'h4000, 2'd3);
    send_request(32'd0, 16'h8000, SelMinus);
    send_request(32'd0, 16'h4001, SelPlus);
    send_request(32'd0, 16'hC000, 2'd0);
    send_request(32'd0, 16'h3FFF, 2'd0);
    send_request(32'h0000_FFFF, 16'h2000, SelPlus);
    send_request(32'h5555_5555, 16'hAAAA, SelMinus);
    write_scale(16'hFFFF);
    send_request(32'd0, 16'd0, SelPlus);
    send_request(32'd0, 16'h8000, SelMinus);
    send_request(32'd2, 16'h0001, 2'd3);
    send_request(32'hFFFF_FFFF, 16'h7FFF, SelPlus);

    // random phases across scale settings and idling patterns
    for (int ph = 0; ph < 6; ph++) begin
      write_scale(scales[ph]);
      idle_pct = pcts[ph % 4];
      random_burst(255);
    end

    start <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (Latency + 4) @(negedge clk_i);
    $display("covered %0d requests and %0d samples over six scale settings",
             request_count, sample_count);
    if (fail_count == 0) $display("testbench: PASS");
    else $display("testbench: FAIL");
    $finish;
  end

endmodule

/* filelist.f */
rtl/bmg_pkg.sv
rtl/bmg_log_cell.sv
rtl/bmg_sqrt_cell.sv
rtl/bmg_cos.sv
rtl/box_muller_gaussian_sample.sv
tb/gauss_sample_checker.sv
tb/testbench.sv
